/* hdl/frame_allocator_fifo_owner_assert.svh */
// Assertion macros shared by the frame allocator RTL.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef FRAME_ALLOCATOR_FIFO_OWNER_ASSERT_SVH
`define FRAME_ALLOCATOR_FIFO_OWNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FAO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FAO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fao_pkg.sv */
// Types and constants of the frame allocator.
// No dependencies; used by the interfaces and every module.
package fao_pkg;

  localparam int PTR_W  = 6;   // free FIFO pointer and frame number
  localparam int DEPTH  = 64;  // entries of the free FIFO and owner table
  localparam int SIZE_W = 24;
  localparam int PAGE_W = 16;
  localparam int JOB_W  = 8;
  localparam int CNT_W  = 7;
  localparam int ADDR_W = 22;
  localparam int OWN_W  = 9;

  typedef logic [PTR_W-1:0] frame_t;
  typedef logic [OWN_W-1:0] owner_t;

  // Bit 8 set marks a frame as free; bits 7..0 hold the owning job.
  localparam owner_t OWNER_FREE = 9'h100;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_GRANT   = 2'd0,
    STAT_OOM     = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_FREED   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ALLOC,
    ST_FREE,
    ST_REPLY
  } state_t;

  // Access requests from the controller to the frame store.
  typedef struct packed {
    logic   fifo_we;
    frame_t fifo_waddr;
    frame_t fifo_wdata;
    logic   fifo_re;
    frame_t fifo_raddr;
    logic   own_we;
    frame_t own_waddr;
    owner_t own_wdata;
    logic   own_re;
    frame_t own_raddr;
  } mem_req_t;

endpackage

/* hdl/fao_cmd_if.sv */
// Command channel of the frame allocator: valid/ready plus the command beat.
// Depends on fao_pkg for the field widths.
interface fao_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [fao_pkg::SIZE_W-1:0]  request_size;
  logic [fao_pkg::JOB_W-1:0]   job_id;

  modport source (output valid, command, request_size, job_id, input ready);
  modport sink   (input valid, command, request_size, job_id, output ready);
endinterface

/* hdl/fao_res_if.sv */
// Result channel of the frame allocator: valid/ready plus the result beat.
// Depends on fao_pkg for the field widths.
interface fao_res_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [fao_pkg::PTR_W-1:0]   frame_index;
  logic [fao_pkg::ADDR_W-1:0]  frame_address;
  logic [fao_pkg::CNT_W-1:0]   frame_count;
  logic                        last;

  modport source (output valid, status, frame_index, frame_address, frame_count, last,
                  input ready);
  modport sink   (input valid, status, frame_index, frame_address, frame_count, last,
                  output ready);
endinterface

/* hdl/fao_div.sv */
// Restoring divider, one quotient bit per cycle, for the frame count.
// Depends on fao_pkg for operand widths.
module fao_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fao_pkg::SIZE_W-1:0]  dividend,
  input  logic [fao_pkg::PAGE_W-1:0]  divisor,
  output logic                        done,
  output logic [fao_pkg::SIZE_W-1:0]  quot,
  output logic                        rem_nz
);

  localparam int CW = $clog2(fao_pkg::SIZE_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CW-1:0]               cnt_r;
  logic [fao_pkg::SIZE_W-1:0]  quot_r;
  logic [fao_pkg::PAGE_W-1:0]  rem_r;
  logic [fao_pkg::PAGE_W-1:0]  dvs_r;

  logic [fao_pkg::PAGE_W:0]    shifted;
  logic [fao_pkg::PAGE_W:0]    diff;
  logic                        fits;

  assign shifted = {rem_r, quot_r[fao_pkg::SIZE_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(fao_pkg::SIZE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient register starts as the dividend and shifts in result bits.
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[fao_pkg::SIZE_W-2:0], fits};
      rem_r  <= fits ? diff[fao_pkg::PAGE_W-1:0] : shifted[fao_pkg::PAGE_W-1:0];
    end
  end

  assign done   = done_r;
  assign quot   = quot_r;
  assign rem_nz = rem_r != '0;

endmodule

/* hdl/fao_store.sv */
// Frame store: the free-frame FIFO memory and the owner table memory.
// Both are synchronous, with one write and one read port and a registered read.
module fao_store (
  input  logic               clk,
  input  fao_pkg::mem_req_t  req,
  output fao_pkg::frame_t    fifo_rdata,
  output fao_pkg::owner_t    own_rdata
);

  fao_pkg::frame_t fifo_mem [fao_pkg::DEPTH];
  fao_pkg::owner_t own_mem  [fao_pkg::DEPTH];
  fao_pkg::frame_t fifo_rdata_r;
  fao_pkg::owner_t own_rdata_r;

  always_ff @(posedge clk) begin
    if (req.fifo_we) begin
      fifo_mem[req.fifo_waddr] <= req.fifo_wdata;
    end
    if (req.fifo_re) begin
      fifo_rdata_r <= fifo_mem[req.fifo_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.own_we) begin
      own_mem[req.own_waddr] <= req.own_wdata;
    end
    if (req.own_re) begin
      own_rdata_r <= own_mem[req.own_raddr];
    end
  end

  assign fifo_rdata = fifo_rdata_r;
  assign own_rdata  = own_rdata_r;

endmodule

/* hdl/frame_allocator_fifo_owner.sv */
// Page-frame allocator. After reset the block fills all DEPTH entries of its
// free-frame FIFO and owner table and takes no command beat until that is
// done; page_size writes are taken throughout. A command beat is taken only
// when the controller is idle. An allocate beat is accepted, goes through the
// bit-serial divider that works out ceil(size / page_size), then gives one
// granted frame per cycle while the result channel does not stall, each frame
// being one FIFO read; an allocate that is rejected, whether for a zero size,
// a zero page size or a shortage of frames, gives a single result beat from
// the reply state (zero size and zero page size skip the divider). A free
// beat walks the owner table one frame a cycle through its read port, then
// gives its result beat. Stalls on the result channel hold the controller in
// its allocate or reply state; the result register lets a new command beat be
// taken while the final result of the previous one still waits.
// Depends on fao_pkg, fao_cmd_if, fao_res_if, fao_div, fao_store and the
// assertion macro header.
`include "frame_allocator_fifo_owner_assert.svh"

module frame_allocator_fifo_owner #(
  parameter int FRAME_TOTAL = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [fao_pkg::PAGE_W-1:0]  cfg_wr_data,
  fao_cmd_if.sink                     in_cmd,
  fao_res_if.source                   out_res
);

  // Frame count as the 7-bit counter value; the tail starts just past the
  // last preloaded frame, wrapping to zero for a full table.
  localparam logic [fao_pkg::CNT_W-1:0] NFR      = fao_pkg::CNT_W'(FRAME_TOTAL);
  localparam fao_pkg::frame_t           TAIL_RST = NFR[fao_pkg::PTR_W-1:0];
  localparam int                        NEED_W   = fao_pkg::SIZE_W + 1;

  fao_pkg::state_t                state_r, state_nxt;
  logic [fao_pkg::PAGE_W-1:0]     page_size_r;
  logic [fao_pkg::JOB_W-1:0]      job_r, job_nxt;
  fao_pkg::frame_t                head_r, head_nxt;
  fao_pkg::frame_t                tail_r, tail_nxt;
  logic [fao_pkg::CNT_W-1:0]      free_count_r, free_count_nxt;
  logic [fao_pkg::CNT_W-1:0]      alloc_left_r, alloc_left_nxt;
  fao_pkg::frame_t                clr_idx_r, clr_idx_nxt;
  logic [fao_pkg::CNT_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                           chk_valid_r, chk_valid_nxt;
  fao_pkg::frame_t                chk_idx_r, chk_idx_nxt;
  logic [fao_pkg::CNT_W-1:0]      freed_r, freed_nxt;
  fao_pkg::status_t               reply_status_r, reply_status_nxt;
  logic [fao_pkg::CNT_W-1:0]      reply_count_r, reply_count_nxt;

  // Result register.
  logic                           out_valid_r, out_valid_nxt;
  fao_pkg::status_t               out_status_r, out_status_nxt;
  fao_pkg::frame_t                out_index_r, out_index_nxt;
  logic [fao_pkg::ADDR_W-1:0]     out_addr_r, out_addr_nxt;
  logic [fao_pkg::CNT_W-1:0]      out_count_r, out_count_nxt;
  logic                           out_last_r, out_last_nxt;

  fao_pkg::mem_req_t              mem_req;
  fao_pkg::frame_t                fifo_rdata;
  fao_pkg::owner_t                own_rdata;

  logic                           div_start;
  logic                           div_done;
  logic [fao_pkg::SIZE_W-1:0]     div_quot;
  logic                           div_rem_nz;

  logic                           in_fire;
  logic                           out_free;
  logic                           alloc_bad;
  logic [NEED_W-1:0]              need;
  logic                           oom;
  logic                           owned;
  logic                           scan_done;
  logic                           clr_last;
  logic                           alloc_emit;
  logic [fao_pkg::ADDR_W-1:0]     grant_addr;

  // Helpers for the checks at the end of the module.
  logic                           left_ok;
  logic                           own_clash;
  logic [fao_pkg::CNT_W-1:0]      count_less;

  fao_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_cmd.request_size),
    .divisor  (page_size_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  fao_store u_store (
    .clk        (clk),
    .req        (mem_req),
    .fifo_rdata (fifo_rdata),
    .own_rdata  (own_rdata)
  );

  assign in_cmd.ready = state_r == fao_pkg::ST_IDLE;
  assign in_fire      = in_cmd.valid && in_cmd.ready;
  // The result register may be loaded when empty or when its beat leaves now.
  assign out_free     = !out_valid_r || out_res.ready;
  assign alloc_bad    = (in_cmd.request_size == '0) || (page_size_r == '0);
  assign div_start    = in_fire && (in_cmd.command == fao_pkg::CMD_ALLOC) && !alloc_bad;

  // Frames needed: the quotient, rounded up when anything is left over.
  assign need         = {1'b0, div_quot} + NEED_W'(div_rem_nz);
  assign oom          = need > NEED_W'(free_count_r);

  // Owner entry read last cycle belongs to the releasing job.
  assign owned        = chk_valid_r && !own_rdata[fao_pkg::OWN_W-1] &&
                        (own_rdata[fao_pkg::JOB_W-1:0] == job_r);
  assign scan_done    = (scan_idx_r == NFR) && !chk_valid_r;
  assign clr_last     = clr_idx_r == fao_pkg::frame_t'(fao_pkg::DEPTH - 1);
  assign alloc_emit   = (state_r == fao_pkg::ST_ALLOC) && out_free;
  assign grant_addr   = fao_pkg::ADDR_W'(fifo_rdata) * fao_pkg::ADDR_W'(page_size_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fao_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = fao_pkg::ST_IDLE;
        end
      end
      fao_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd.command == fao_pkg::CMD_FREE) begin
            state_nxt = fao_pkg::ST_FREE;
          end else if (alloc_bad) begin
            state_nxt = fao_pkg::ST_REPLY;
          end else begin
            state_nxt = fao_pkg::ST_DIV;
          end
        end
      end
      fao_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = oom ? fao_pkg::ST_REPLY : fao_pkg::ST_ALLOC;
        end
      end
      fao_pkg::ST_ALLOC: begin
        if (out_free && (alloc_left_r == fao_pkg::CNT_W'(1))) begin
          state_nxt = fao_pkg::ST_IDLE;
        end
      end
      fao_pkg::ST_FREE: begin
        if (scan_done) begin
          state_nxt = fao_pkg::ST_REPLY;
        end
      end
      fao_pkg::ST_REPLY: begin
        if (out_free) begin
          state_nxt = fao_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fao_pkg::ST_CLEAR;
    endcase
  end

  // Datapath, memory requests and the result register.
  always_comb begin
    job_nxt          = job_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    free_count_nxt   = free_count_r;
    alloc_left_nxt   = alloc_left_r;
    clr_idx_nxt      = clr_idx_r;
    scan_idx_nxt     = scan_idx_r;
    chk_valid_nxt    = chk_valid_r;
    chk_idx_nxt      = chk_idx_r;
    freed_nxt        = freed_r;
    reply_status_nxt = reply_status_r;
    reply_count_nxt  = reply_count_r;

    out_valid_nxt    = out_valid_r && !out_res.ready;
    out_status_nxt   = out_status_r;
    out_index_nxt    = out_index_r;
    out_addr_nxt     = out_addr_r;
    out_count_nxt    = out_count_r;
    out_last_nxt     = out_last_r;

    mem_req            = '0;

    unique case (state_r)
      fao_pkg::ST_CLEAR: begin
        // Preload the FIFO with frames in order and mark every frame free.
        mem_req.fifo_we    = 1'b1;
        mem_req.fifo_waddr = clr_idx_r;
        mem_req.fifo_wdata = ({1'b0, clr_idx_r} < NFR) ? clr_idx_r : '0;
        mem_req.own_we     = 1'b1;
        mem_req.own_waddr  = clr_idx_r;
        mem_req.own_wdata  = fao_pkg::OWNER_FREE;
        clr_idx_nxt        = clr_idx_r + fao_pkg::frame_t'(1);
      end
      fao_pkg::ST_IDLE: begin
        if (in_fire) begin
          job_nxt          = in_cmd.job_id;
          scan_idx_nxt     = '0;
          chk_valid_nxt    = 1'b0;
          freed_nxt        = '0;
          reply_status_nxt = fao_pkg::STAT_INVALID;
          reply_count_nxt  = '0;
        end
      end
      fao_pkg::ST_DIV: begin
        if (div_done) begin
          if (oom) begin
            reply_status_nxt = fao_pkg::STAT_OOM;
            reply_count_nxt  = free_count_r;
          end else begin
            // Need fits in the counter here since it is at most the free count.
            alloc_left_nxt     = need[fao_pkg::CNT_W-1:0];
            mem_req.fifo_re    = 1'b1;
            mem_req.fifo_raddr = head_r;
          end
        end
      end
      fao_pkg::ST_ALLOC: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = fao_pkg::STAT_GRANT;
          out_index_nxt     = fifo_rdata;
          out_addr_nxt      = grant_addr;
          out_count_nxt     = '0;
          out_last_nxt      = alloc_left_r == fao_pkg::CNT_W'(1);
          mem_req.own_we    = 1'b1;
          mem_req.own_waddr = fifo_rdata;
          mem_req.own_wdata = {1'b0, job_r};
          head_nxt          = head_r + fao_pkg::frame_t'(1);
          free_count_nxt    = free_count_r - fao_pkg::CNT_W'(1);
          alloc_left_nxt    = alloc_left_r - fao_pkg::CNT_W'(1);
          // Fetch the next frame while this one goes out.
          if (alloc_left_r != fao_pkg::CNT_W'(1)) begin
            mem_req.fifo_re    = 1'b1;
            mem_req.fifo_raddr = head_r + fao_pkg::frame_t'(1);
          end
        end
      end
      fao_pkg::ST_FREE: begin
        // Read frame i while frame i-1, read last cycle, is checked and
        // released; the two never share an address.
        if (scan_idx_r < NFR) begin
          mem_req.own_re    = 1'b1;
          mem_req.own_raddr = scan_idx_r[fao_pkg::PTR_W-1:0];
          chk_valid_nxt     = 1'b1;
          chk_idx_nxt       = scan_idx_r[fao_pkg::PTR_W-1:0];
          scan_idx_nxt      = scan_idx_r + fao_pkg::CNT_W'(1);
        end else begin
          chk_valid_nxt = 1'b0;
        end
        if (owned) begin
          mem_req.own_we     = 1'b1;
          mem_req.own_waddr  = chk_idx_r;
          mem_req.own_wdata  = fao_pkg::OWNER_FREE;
          mem_req.fifo_we    = 1'b1;
          mem_req.fifo_waddr = tail_r;
          mem_req.fifo_wdata = chk_idx_r;
          tail_nxt           = tail_r + fao_pkg::frame_t'(1);
          free_count_nxt     = free_count_r + fao_pkg::CNT_W'(1);
          freed_nxt          = freed_r + fao_pkg::CNT_W'(1);
        end
        if (scan_done) begin
          reply_status_nxt = fao_pkg::STAT_FREED;
          reply_count_nxt  = freed_r;
        end
      end
      fao_pkg::ST_REPLY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = reply_status_r;
          out_index_nxt  = '0;
          out_addr_nxt   = '0;
          out_count_nxt  = reply_count_r;
          out_last_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fao_pkg::ST_CLEAR;
      page_size_r  <= fao_pkg::PAGE_W'(4096);
      head_r       <= '0;
      tail_r       <= TAIL_RST;
      free_count_r <= NFR;
      clr_idx_r    <= '0;
      chk_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) begin
        page_size_r <= cfg_wr_data;
      end
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      free_count_r <= free_count_nxt;
      clr_idx_r    <= clr_idx_nxt;
      chk_valid_r  <= chk_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r          <= job_nxt;
    alloc_left_r   <= alloc_left_nxt;
    scan_idx_r     <= scan_idx_nxt;
    chk_idx_r      <= chk_idx_nxt;
    freed_r        <= freed_nxt;
    reply_status_r <= reply_status_nxt;
    reply_count_r  <= reply_count_nxt;
    out_status_r   <= out_status_nxt;
    out_index_r    <= out_index_nxt;
    out_addr_r     <= out_addr_nxt;
    out_count_r    <= out_count_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = out_status_r;
  assign out_res.frame_index   = out_index_r;
  assign out_res.frame_address = out_addr_r;
  assign out_res.frame_count   = out_count_r;
  assign out_res.last          = out_last_r;

  assign left_ok    = (alloc_left_r != '0) && (alloc_left_r <= free_count_r);
  assign own_clash  = mem_req.own_we && mem_req.own_re &&
                      (mem_req.own_waddr == mem_req.own_raddr);
  assign count_less = free_count_r - fao_pkg::CNT_W'(1);

  `FAO_ASSERT_SAME(a_count_bound, 1'b1, free_count_r <= NFR, "free count above frame total")
  `FAO_ASSERT_SAME(a_alloc_left, state_r == fao_pkg::ST_ALLOC, left_ok, "frames left out of range")
  `FAO_ASSERT_SAME(a_own_no_overlap, 1'b1, !own_clash, "owner read and write hit one entry")
  `FAO_ASSERT_NEXT(a_grant_takes, alloc_emit, free_count_r == $past(count_less), "grant not counted")

endmodule

/* dv/frame_allocator_fifo_owner_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the page-frame allocator: directed table, then random phases.
// Depends on fao_pkg, fao_cmd_if, fao_res_if and frame_allocator_fifo_owner.

module frame_allocator_fifo_owner_test;
  import fao_pkg::*;

  localparam int          FRAMES       = 64;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int          SETTLE       = 8;   // idle cycles before a page_size write
  localparam int          DRAIN_CYCLES = 40;  // quiet cycles after the last result beat
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 44;
  localparam logic [23:0] SIZE_MAX     = 24'hFFFFFF;

  // One result beat as the allocator should emit it.
  typedef struct packed {
    status_t     status;
    frame_t      index;
    logic [21:0] address;
    logic [6:0]  count;
    logic        last;
  } reply_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_PAGE
  } row_kind_t;

  // A row of the directed table. Where typed is set, the single reply is written out by hand:
  // status and count as given, frame fields zero, last set. Otherwise the predictor decides.
  typedef struct packed {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [23:0] size;
    logic [7:0]  job;
    logic [15:0] page;
    logic        typed;
    status_t     status;
    logic [6:0]  count;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [26] = '{
    // Zero size is refused outright, and the very first grant is frame 0 at address 0.
    '{ROW_ITEM, CMD_ALLOC, 24'd0,      8'h00, 16'd0,     1'b1, STAT_INVALID, 7'd0},
    '{ROW_ITEM, CMD_ALLOC, 24'd1,      8'hFF, 16'd0,     1'b1, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_ALLOC, 24'd4097,   8'h01, 16'd0,     1'b0, STAT_GRANT,   7'd0},
    // Largest size cannot fit: the free count comes back instead.
    '{ROW_ITEM, CMD_ALLOC, SIZE_MAX,   8'h02, 16'd0,     1'b1, STAT_OOM,     7'd61},
    '{ROW_ITEM, CMD_FREE,  24'd0,      8'hFF, 16'd0,     1'b1, STAT_FREED,   7'd1},
    // Freeing a job that owns nothing still gives one beat, with a count of zero.
    '{ROW_ITEM, CMD_FREE,  24'd0,      8'h55, 16'd0,     1'b1, STAT_FREED,   7'd0},
    // Take every remaining frame, so the FIFO head wraps past the frame freed above.
    '{ROW_ITEM, CMD_ALLOC, 24'd253952, 8'h03, 16'd0,     1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_ALLOC, 24'd1,      8'h04, 16'd0,     1'b1, STAT_OOM,     7'd0},
    // The size field of a free is ignored.
    '{ROW_ITEM, CMD_FREE,  SIZE_MAX,   8'h03, 16'd0,     1'b1, STAT_FREED,   7'd62},
    '{ROW_ITEM, CMD_FREE,  24'd0,      8'h01, 16'd0,     1'b1, STAT_FREED,   7'd2},
    // The whole memory in one request, back again, then one page too many.
    '{ROW_ITEM, CMD_ALLOC, 24'd262144, 8'h80, 16'd0,     1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_FREE,  24'd0,      8'h80, 16'd0,     1'b1, STAT_FREED,   7'd64},
    '{ROW_ITEM, CMD_ALLOC, 24'd262145, 8'h06, 16'd0,     1'b1, STAT_OOM,     7'd64},
    // A zero page size makes every allocate invalid, while free carries on working.
    '{ROW_PAGE, CMD_ALLOC, 24'd0,      8'h00, 16'd0,     1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_ALLOC, 24'd100,    8'h07, 16'd0,     1'b1, STAT_INVALID, 7'd0},
    '{ROW_ITEM, CMD_ALLOC, SIZE_MAX,   8'h07, 16'd0,     1'b1, STAT_INVALID, 7'd0},
    '{ROW_ITEM, CMD_FREE,  24'd0,      8'h00, 16'd0,     1'b1, STAT_FREED,   7'd0},
    // Single-byte pages: the address equals the frame number.
    '{ROW_PAGE, CMD_ALLOC, 24'd0,      8'h00, 16'd1,     1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_ALLOC, 24'd64,     8'h09, 16'd0,     1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_FREE,  24'd0,      8'h09, 16'd0,     1'b1, STAT_FREED,   7'd64},
    '{ROW_ITEM, CMD_ALLOC, 24'd65,     8'h09, 16'd0,     1'b1, STAT_OOM,     7'd64},
    // Largest page: three full pages, then one byte over, then a size that cannot fit.
    '{ROW_PAGE, CMD_ALLOC, 24'd0,      8'h00, 16'd65535, 1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_ALLOC, 24'd196605, 8'hAA, 16'd0,     1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_ALLOC, 24'd196606, 8'h54, 16'd0,     1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_ALLOC, SIZE_MAX,   8'h00, 16'd0,     1'b0, STAT_GRANT,   7'd0},
    '{ROW_ITEM, CMD_FREE,  24'd0,      8'hAA, 16'd0,     1'b1, STAT_FREED,   7'd3}
  };

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [PAGE_W-1:0] cfg_wr_data;

  fao_cmd_if cmd_chan ();
  fao_res_if res_chan ();

  frame_allocator_fifo_owner #(
    .FRAME_TOTAL (FRAMES)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (cmd_chan),
    .out_res     (res_chan)
  );

  // Our own copy of the allocator: free-frame ring, owner of each frame, free count
  // and the page size currently programmed.
  frame_t      free_ring [FRAMES];
  frame_t      ring_head;
  frame_t      ring_tail;
  logic [6:0]  frames_free;
  owner_t      frame_owner [FRAMES];
  logic [15:0] page_bytes;

  reply_t      replies_due [$];   // result beats still owed by the allocator, oldest first
  int          mismatches;
  int unsigned stall_left;
  int unsigned cycle_count;
  logic        quiet_phase;       // when set, neither side inserts gaps
  reply_t      want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic reply_t mk_reply(status_t status, frame_t index, logic [21:0] address,
                                      logic [6:0] count, logic last);
    reply_t r;
    r.status  = status;
    r.index   = index;
    r.address = address;
    r.count   = count;
    r.last    = last;
    return r;
  endfunction

  // Applies one accepted command to the copy of the allocator and returns the beats it
  // should produce.
  function automatic void apply_command(input cmd_t cmd, input logic [23:0] size,
                                        input logic [7:0] job, ref reply_t beats[$]);
    int unsigned need;
    logic [6:0]  freed;
    frame_t      f;
    logic [31:0] product;
    beats.delete();
    if (cmd == CMD_FREE) begin
      // Ascending scan, so frames return to the ring tail in index order.
      freed = '0;
      for (int i = 0; i < FRAMES; i++) begin
        if (!frame_owner[i][8] && frame_owner[i][7:0] == job) begin
          frame_owner[i]       = OWNER_FREE;
          free_ring[ring_tail] = frame_t'(i);
          ring_tail++;
          frames_free++;
          freed++;
        end
      end
      beats.push_back(mk_reply(STAT_FREED, '0, '0, freed, 1'b1));
      return;
    end
    if (size == '0 || page_bytes == '0) begin
      beats.push_back(mk_reply(STAT_INVALID, '0, '0, '0, 1'b1));
      return;
    end
    need = (int'(size) + int'(page_bytes) - 1) / int'(page_bytes);
    if (need > frames_free) begin
      beats.push_back(mk_reply(STAT_OOM, '0, '0, frames_free, 1'b1));
      return;
    end
    for (int k = 0; k < need; k++) begin
      f = free_ring[ring_head];
      ring_head++;
      frame_owner[f] = {1'b0, job};
      frames_free--;
      product = 32'(f) * 32'(page_bytes);
      beats.push_back(mk_reply(STAT_GRANT, f, product[21:0], '0, (k + 1 == need)));
    end
  endfunction

  // Gap length for either side: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  // Offers one command beat after a random gap and predicts its replies once it is taken.
  // Valid is left high so that a back-to-back beat needs no second assignment in the step.
  task automatic send_command(input cmd_t cmd, input logic [23:0] size, input logic [7:0] job,
                              input logic typed, input status_t typed_status,
                              input logic [6:0] typed_count);
    int unsigned gap;
    reply_t      beats [$];
    gap = pick_gap();
    if (gap != 0) begin
      cmd_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_chan.valid        <= 1'b1;
    cmd_chan.command      <= cmd;
    cmd_chan.request_size <= size;
    cmd_chan.job_id       <= job;
    do @(posedge clk); while (!cmd_chan.ready);
    apply_command(cmd, size, job, beats);
    if (typed) begin
      replies_due.push_back(mk_reply(typed_status, '0, '0, typed_count, 1'b1));
    end else begin
      foreach (beats[i]) replies_due.push_back(beats[i]);
    end
  endtask

  // page_size is only changed once every owed beat has come back and the block has settled.
  task automatic write_page_size(input logic [15:0] value);
    cmd_chan.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    page_bytes = value;
    cfg_wr_en  <= 1'b0;
  endtask

  // Result side: every beat taken is compared field by field with the oldest one owed, and
  // ready is dropped in random stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_chan.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_chan.valid && res_chan.ready) begin
        if (replies_due.size() == 0) begin
          $error("result beat with none owed: status %0d, frame %0d, count %0d",
                 res_chan.status, res_chan.frame_index, res_chan.frame_count);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", 32'(want.status), 32'(res_chan.status));
          check_field("frame_index", 32'(want.index), 32'(res_chan.frame_index));
          check_field("frame_address", 32'(want.address), 32'(res_chan.frame_address));
          check_field("frame_count", 32'(want.count), 32'(res_chan.frame_count));
          check_field("last", 32'(want.last), 32'(res_chan.last));
        end
      end
      if (stall_left != 0) begin
        res_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        res_chan.ready <= (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // Watchdog: a hang or a beat that never arrives ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("frame_allocator_fifo_owner test failed");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned need;
    int unsigned span;
    logic [15:0] page;
    logic [23:0] size;
    logic [7:0]  job;
    logic [7:0]  jobs [4];
    cmd_t        cmd;
    stim_row_t   row;

    rst_n                 <= 1'b0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= '0;
    cmd_chan.valid        <= 1'b0;
    cmd_chan.command      <= CMD_ALLOC;
    cmd_chan.request_size <= '0;
    cmd_chan.job_id       <= '0;
    mismatches  = 0;
    quiet_phase = 1'b0;

    // Post-reset picture: frames 0 to 63 queued in order, all unowned, 4 KiB pages.
    for (int i = 0; i < FRAMES; i++) begin
      free_ring[i]   = frame_t'(i);
      frame_owner[i] = OWNER_FREE;
    end
    ring_head   = '0;
    ring_tail   = frame_t'(FRAMES);
    frames_free = 7'(FRAMES);
    page_bytes  = 16'd4096;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The first command waits out the clearing pass through ready.
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_PAGE) begin
        write_page_size(row.page);
      end else begin
        send_command(row.cmd, row.size, row.job, row.typed, row.status, row.count);
      end
    end

    // Random phases, each with a page size written at its start; the extremes and zero are among them.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       page = 16'd1;
        1:       page = 16'd65535;
        3:       page = 16'd4096;
        4:       page = 16'd0;
        5:       page = 16'($urandom_range(2, 64));
        6:       page = 16'($urandom_range(256, 8192));
        7:       page = 16'd65535;
        default: page = 16'($urandom_range(1, 65535));
      endcase
      write_page_size(page);
      quiet_phase = (p == 3);
      // A handful of jobs per phase, so that frees usually find frames to release.
      foreach (jobs[j]) jobs[j] = 8'($urandom_range(0, 255));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r   = $urandom_range(0, 99);
        job = jobs[$urandom_range(0, 3)];
        cmd = CMD_ALLOC;
        if (r < 25) begin
          cmd  = CMD_FREE;
          size = 24'($urandom);
          if ($urandom_range(0, 9) == 0) job = 8'($urandom_range(0, 255));
        end else if (r < 80) begin
          // Well-formed request: a modest page count, the last page partly or fully used.
          need = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
          span = need * page;
          if (page == '0 || span > SIZE_MAX) begin
            size = 24'($urandom_range(1, SIZE_MAX));
          end else begin
            size = 24'(span - $urandom_range(0, page - 1));
          end
        end else if (r < 95) begin
          size = 24'($urandom);
          job  = 8'($urandom_range(0, 255));
        end else begin
          size = '0;
        end
        send_command(cmd, size, job, 1'b0, STAT_GRANT, '0);
      end
    end
    quiet_phase = 1'b0;

    cmd_chan.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("frame_allocator_fifo_owner test passed");
    end else begin
      $display("frame_allocator_fifo_owner test failed");
    end
    $finish;
  end

endmodule
